// ----- src/olt_pkg.sv -----
package olt_pkg;

    // request action codes
    typedef enum logic [1:0] {
        ACT_LOCK   = 2'd0,
        ACT_UNLOCK = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ACCESS  = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    localparam int OBJECT_W  = 32;
    localparam int SESSION_W = 64;

    // summary of one table search
    typedef struct packed {
        logic                 hit;
        logic                 owner_eq;
        logic                 full;
        logic [SESSION_W-1:0] owner;
    } search_res_t;

    // table update for one request
    typedef struct packed {
        logic insert;
        logic release_hit;
    } table_cmd_t;

endpackage

// ----- src/olt_search.sv -----
module olt_search
    import olt_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic [ENTRIES-1:0]   valid,
    input  logic [OBJECT_W-1:0]  objects [ENTRIES],
    input  logic [SESSION_W-1:0] owners [ENTRIES],
    input  logic [OBJECT_W-1:0]  object_id,
    input  logic [SESSION_W-1:0] session_id,
    output logic [ENTRIES-1:0]   hit_vec,
    output logic [ENTRIES-1:0]   free_vec,
    output search_res_t          res
);

    logic [ENTRIES-1:0]   empty_vec;
    logic [SESSION_W-1:0] owner_or;

    // per-entry match; an object sits in at most one valid entry
    always_comb
    begin
        owner_or = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            hit_vec[k] = valid[k] && (objects[k] == object_id);
            if (hit_vec[k])
            begin
                owner_or = owner_or | owners[k];
            end
        end
    end

    // lowest free entry, isolated as a one-hot vector
    assign empty_vec = ~valid;
    assign free_vec  = empty_vec & (~empty_vec + ENTRIES'(1));

    always_comb
    begin
        res.hit      = |hit_vec;
        res.owner    = owner_or;
        res.owner_eq = (owner_or == session_id);
        res.full     = &valid;
    end

endmodule

// ----- src/olt_table.sv -----
module olt_table
    import olt_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  table_cmd_t           cmd,
    input  logic [ENTRIES-1:0]   hit_vec,
    input  logic [ENTRIES-1:0]   free_vec,
    input  logic [OBJECT_W-1:0]  object_id,
    input  logic [SESSION_W-1:0] session_id,
    output logic [ENTRIES-1:0]   valid,
    output logic [OBJECT_W-1:0]  objects [ENTRIES],
    output logic [SESSION_W-1:0] owners [ENTRIES]
);

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [OBJECT_W-1:0]  object_reg [ENTRIES];
    logic [SESSION_W-1:0] owner_reg [ENTRIES];

    // valid marks: set on insert, cleared on release
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.insert)
        begin
            valid_next = valid_reg | free_vec;
        end
        else if (cmd.release_hit)
        begin
            valid_next = valid_reg & ~hit_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload, written into the chosen free slot
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (cmd.insert && free_vec[k])
            begin
                object_reg[k] <= object_id;
                owner_reg[k]  <= session_id;
            end
        end
    end

    assign valid   = valid_reg;
    assign objects = object_reg;
    assign owners  = owner_reg;

endmodule

// ----- src/object_lock_table.sv -----
// object lock table: maps object identifiers to owning session identifiers
//
// a request (action, object_id, session_id) is taken on a rising edge with
// start high and busy low; busy stays low, so a request may come in every
// cycle. action selects lock, unlock or query (code three acts as query).
// each request gives exactly one result on status, locked and
// owner_session, marked by done for one cycle. the taking edge loads the
// request register, which feeds the result register; the table search
// is done combinationally between them, and the table update is written
// at the same edge as the result register. done is registered from the
// request register's valid bit. a table update is in place before the
// following request is searched, so back-to-back requests see each
// other's effects. throughput is one request per cycle, set by the
// parallel match over all TABLE_ENTRIES slots.
// reset clears every valid mark and drops any request or result in
// flight; slot payload is not cleared. the receiver cannot stall: a result
// is present for its one cycle only and must be taken then.
module object_lock_table
    import olt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [OBJECT_W-1:0]  object_id,
    input  logic [SESSION_W-1:0] session_id,
    output logic                 done,
    output logic [1:0]           status,
    output logic                 locked,
    output logic [SESSION_W-1:0] owner_session
);

    logic                 req_valid_reg;
    logic [1:0]           action_reg;
    logic [OBJECT_W-1:0]  object_reg;
    logic [SESSION_W-1:0] session_reg;

    logic                 done_reg;
    logic [1:0]           status_reg;
    logic                 locked_reg;
    logic [SESSION_W-1:0] owner_reg;

    status_t              status_next;
    logic                 locked_next;
    logic [SESSION_W-1:0] owner_next;
    table_cmd_t           cmd;

    logic [TABLE_ENTRIES-1:0] valid;
    logic [OBJECT_W-1:0]      objects [TABLE_ENTRIES];
    logic [SESSION_W-1:0]     owners [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic [TABLE_ENTRIES-1:0] free_vec;
    search_res_t              res;

    // one request per cycle, never held off
    assign busy = 1'b0;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg  <= action;
            object_reg  <= object_id;
            session_reg <= session_id;
        end
    end

    olt_search #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_search (
        .valid      (valid),
        .objects    (objects),
        .owners     (owners),
        .object_id  (object_reg),
        .session_id (session_reg),
        .hit_vec    (hit_vec),
        .free_vec   (free_vec),
        .res        (res)
    );

    olt_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .hit_vec    (hit_vec),
        .free_vec   (free_vec),
        .object_id  (object_reg),
        .session_id (session_reg),
        .valid      (valid),
        .objects    (objects),
        .owners     (owners)
    );

    // decode the request against the search result
    always_comb
    begin
        status_next     = ST_OK;
        locked_next     = 1'b0;
        owner_next      = '0;
        cmd.insert      = 1'b0;
        cmd.release_hit = 1'b0;
        case (action_reg)
            ACT_LOCK:
            begin
                if (res.hit)
                begin
                    if (!res.owner_eq)
                    begin
                        status_next = ST_NO_ACCESS;
                    end
                end
                else if (res.full)
                begin
                    status_next = ST_TABLE_FULL;
                end
                else
                begin
                    cmd.insert = req_valid_reg;
                end
            end
            ACT_UNLOCK:
            begin
                if (!res.hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (!res.owner_eq)
                begin
                    status_next = ST_NO_ACCESS;
                end
                else
                begin
                    cmd.release_hit = req_valid_reg;
                end
            end
            default:
            begin
                // query, and the spare code alike
                locked_next = res.hit;
                owner_next  = res.owner;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg <= status_next;
            locked_reg <= locked_next;
            owner_reg  <= owner_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign locked        = locked_reg;
    assign owner_session = owner_reg;

    // every taken request gives a result on done
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
    else $error("request without result");

    // a result only follows a registered request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_valid_reg))
    else $error("result without request");

    // a locked report is always a successful query
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && locked) |-> (status == ST_OK))
    else $error("locked report with error status");

    // no owner shown unless the object is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !locked) |-> (owner_session == '0))
    else $error("owner shown for unlocked object");

    // insert and release never in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.insert && cmd.release_hit))
    else $error("table insert and release together");

endmodule
